[src/assert_macros.svh]
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define DTRD_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("invariant violated");

// Check that a condition in one cycle implies another in the next cycle.
`define DTRD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check violated");

`endif

[src/dtrd_pkg.sv]
// Package: widths, types, register map and arctangent table of the radar disc mapper.
`timescale 1ns / 1ps
package dtrd_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int COEFF_WIDTH  = 16;
  localparam int LANE_W       = 16;
  localparam int WORLD_W      = 24;
  localparam int PROD_W       = WORLD_W + COEFF_WIDTH;
  localparam int LOCAL_W      = PROD_W + 4;
  localparam int MAG_W        = LOCAL_W - 1;
  localparam int SHIFT_W      = 6;
  localparam int NORM_W       = 32;
  localparam int NORM_TOP     = 28;
  localparam int ISQ_W        = 62;
  localparam int ISQ_STEPS    = ISQ_W / 2;
  localparam int ROOT_W       = ISQ_STEPS;
  localparam int ISQ_PAY_W    = 3 * NORM_W;
  localparam int CRD_W        = 34;
  localparam int ANG_W        = 34;
  localparam int Q23_W        = 26;
  localparam int SQ_W         = 2 * Q23_W;
  localparam int RAD_W        = 15;
  localparam int CR_W         = RAD_W + 8;
  localparam int QUO_BITS     = 24;
  localparam int DIV_W        = 52;
  localparam int OUT_W        = 16;
  localparam int PADDR_W      = 5;
  localparam int PDATA_W      = 64;

  localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic [RAD_W-1:0]        CLAMP_RESET = 15'd14746;

  typedef enum logic [1:0] {
    REG_COL_X = 2'd0,
    REG_COL_Y = 2'd1,
    REG_COL_Z = 2'd2,
    REG_CLAMP = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic                     valid;
    logic signed [NORM_W-1:0] x;
    logic signed [NORM_W-1:0] y;
    logic signed [NORM_W-1:0] z;
    logic [ISQ_W-1:0]         rad;
  } xf_t;

  typedef struct packed {
    logic                    valid;
    logic signed [CRD_W-1:0] az_y;
    logic signed [CRD_W-1:0] az_x;
    logic signed [CRD_W-1:0] el_y;
    logic signed [CRD_W-1:0] el_x;
  } crd_in_t;

  typedef struct packed {
    logic                    valid;
    logic signed [Q23_W-1:0] az;
    logic signed [Q23_W-1:0] el;
  } crd_out_t;

  typedef struct packed {
    logic                    valid;
    logic signed [OUT_W-1:0] radar_x;
    logic signed [OUT_W-1:0] radar_y;
    logic                    clamped;
  } res_t;

  // atan(2^-i) in Q30 radians, rounded
  function automatic logic signed [ANG_W-1:0] atan_q30(input int i);
    logic signed [ANG_W-1:0] a;
    case (i)
      0:  a = 34'sd843314857;
      1:  a = 34'sd497837829;
      2:  a = 34'sd263043837;
      3:  a = 34'sd133525159;
      4:  a = 34'sd67021687;
      5:  a = 34'sd33543516;
      6:  a = 34'sd16775851;
      7:  a = 34'sd8388437;
      8:  a = 34'sd4194283;
      9:  a = 34'sd2097149;
      10: a = 34'sd1048576;
      11: a = 34'sd524288;
      12: a = 34'sd262144;
      13: a = 34'sd131072;
      14: a = 34'sd65536;
      15: a = 34'sd32768;
      16: a = 34'sd16384;
      17: a = 34'sd8192;
      18: a = 34'sd4096;
      19: a = 34'sd2048;
      20: a = 34'sd1024;
      21: a = 34'sd512;
      22: a = 34'sd256;
      23: a = 34'sd128;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

[src/dtrd_if.sv]
// Valid/ready channel interfaces for world points and radar results.
`timescale 1ns / 1ps
interface dtrd_in_if;
  import dtrd_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [WORLD_W-1:0] world_x;
  logic signed [WORLD_W-1:0] world_y;
  logic signed [WORLD_W-1:0] world_z;
  modport source (output valid, output world_x, output world_y, output world_z, input ready);
  modport sink (input valid, input world_x, input world_y, input world_z, output ready);
endinterface

interface dtrd_out_if;
  import dtrd_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] radar_x;
  logic signed [OUT_W-1:0] radar_y;
  logic                    clamped;
  modport source (output valid, output radar_x, output radar_y, output clamped, input ready);
  modport sink (input valid, input radar_x, input radar_y, input clamped, output ready);
endinterface

[src/dtrd_isqrt.sv]
// Pipelined floor integer square root, one result bit per stage, with a side payload.
`timescale 1ns / 1ps
module dtrd_isqrt (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic [dtrd_pkg::ISQ_W-1:0]       radicand_i,
  input  logic [dtrd_pkg::ISQ_PAY_W-1:0]   pay_i,
  output logic                             valid_o,
  output logic [dtrd_pkg::ROOT_W-1:0]      root_o,
  output logic [dtrd_pkg::ISQ_PAY_W-1:0]   pay_o
);
  import dtrd_pkg::*;

  logic                 vld  [ISQ_STEPS+1];
  logic [ISQ_W-1:0]     rem  [ISQ_STEPS+1];
  logic [ISQ_W-1:0]     root [ISQ_STEPS+1];
  logic [ISQ_PAY_W-1:0] pay  [ISQ_STEPS+1];

  assign vld[0]  = valid_i;
  assign rem[0]  = radicand_i;
  assign root[0] = '0;
  assign pay[0]  = pay_i;

  for (genvar i = 0; i < ISQ_STEPS; i++) begin : g_step
    localparam logic [ISQ_W-1:0] BIT = {{(ISQ_W-1){1'b0}}, 1'b1} << (2 * (ISQ_STEPS - 1 - i));
    logic [ISQ_W-1:0] trial;
    assign trial = root[i] + BIT;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[i+1] <= 1'b0;
      end else if (en_i) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem[i] >= trial) begin
          rem[i+1]  <= rem[i] - trial;
          root[i+1] <= (root[i] >> 1) + BIT;
        end else begin
          rem[i+1]  <= rem[i];
          root[i+1] <= root[i] >> 1;
        end
        pay[i+1] <= pay[i];
      end
    end
  end

  assign valid_o = vld[ISQ_STEPS];
  assign root_o  = root[ISQ_STEPS][ROOT_W-1:0];
  assign pay_o   = pay[ISQ_STEPS];

endmodule

[src/dtrd_xform.sv]
// Affine transform of the world point, block normalization and the x*x+z*z radicand.
`timescale 1ns / 1ps
module dtrd_xform (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic signed [dtrd_pkg::WORLD_W-1:0] world_x_i,
  input  logic signed [dtrd_pkg::WORLD_W-1:0] world_y_i,
  input  logic signed [dtrd_pkg::WORLD_W-1:0] world_z_i,
  input  logic [dtrd_pkg::PDATA_W-1:0]        col_x_i,
  input  logic [dtrd_pkg::PDATA_W-1:0]        col_y_i,
  input  logic [dtrd_pkg::PDATA_W-1:0]        col_z_i,
  output dtrd_pkg::xf_t                       xf_o
);
  import dtrd_pkg::*;

  logic signed [WORLD_W-1:0]     wld  [3];
  logic [PDATA_W-1:0]            col  [3];
  logic signed [COEFF_WIDTH-1:0] coef [3][4];

  logic                      v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q;
  logic signed [PROD_W-1:0]  prod_q [3][3];
  logic signed [LOCAL_W-1:0] loc2_q [3];
  logic signed [LOCAL_W-1:0] loc3_q [3];
  logic signed [LOCAL_W-1:0] loc4_q [3];
  logic [MAG_W-1:0]          mag    [3];
  logic [MAG_W-1:0]          or3_q;
  logic [SHIFT_W-1:0]        msb;
  logic [SHIFT_W-1:0]        amt4_q;
  logic                      right4_q;
  logic signed [NORM_W-1:0]  n5_q [3];
  logic signed [NORM_W-1:0]  n6_q [3];
  logic signed [NORM_W-1:0]  n7_q [3];
  logic signed [2*NORM_W-1:0] xe, ze;
  logic [2*NORM_W-1:0]       xx6_q, zz6_q;
  logic [ISQ_W-1:0]          rad7_q;

  assign wld[0] = world_x_i;
  assign wld[1] = world_y_i;
  assign wld[2] = world_z_i;
  assign col[0] = col_x_i;
  assign col[1] = col_y_i;
  assign col[2] = col_z_i;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      for (int k = 0; k < 4; k++) begin
        coef[a][k] = col[a][LANE_W*k +: COEFF_WIDTH];
      end
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      mag[a] = MAG_W'(loc2_q[a][LOCAL_W-1] ? -loc2_q[a] : loc2_q[a]);
    end
  end

  always_comb begin
    msb = '0;
    for (int b = 0; b < MAG_W; b++) begin
      if (or3_q[b]) msb = SHIFT_W'(b);
    end
  end

  assign xe = (2*NORM_W)'(n5_q[0]);
  assign ze = (2*NORM_W)'(n5_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // products of world coordinates and coefficients
      for (int a = 0; a < 3; a++) begin
        for (int k = 0; k < 3; k++) begin
          prod_q[a][k] <= PROD_W'(wld[k]) * PROD_W'(coef[a][k]);
        end
      end
      // sum with translation in Q.20
      for (int a = 0; a < 3; a++) begin
        loc2_q[a] <= LOCAL_W'(prod_q[a][0]) + LOCAL_W'(prod_q[a][1])
                   + LOCAL_W'(prod_q[a][2]) + (LOCAL_W'(coef[a][3]) <<< 8);
      end
      // magnitude union for the leading-one search
      or3_q <= mag[0] | mag[1] | mag[2];
      loc3_q <= loc2_q;
      // common shift amount
      right4_q <= msb > SHIFT_W'(NORM_TOP);
      amt4_q   <= (msb > SHIFT_W'(NORM_TOP)) ? msb - SHIFT_W'(NORM_TOP)
                                              : SHIFT_W'(NORM_TOP) - msb;
      loc4_q <= loc3_q;
      // normalize, floor on right shifts
      for (int a = 0; a < 3; a++) begin
        n5_q[a] <= right4_q ? NORM_W'(loc4_q[a] >>> amt4_q) : NORM_W'(loc4_q[a] << amt4_q);
      end
      xx6_q <= xe * xe;
      zz6_q <= ze * ze;
      n6_q  <= n5_q;
      rad7_q <= ISQ_W'(xx6_q) + ISQ_W'(zz6_q);
      n7_q   <= n6_q;
    end
  end

  assign xf_o.valid = v7_q;
  assign xf_o.x     = n7_q[0];
  assign xf_o.y     = n7_q[1];
  assign xf_o.z     = n7_q[2];
  assign xf_o.rad   = rad7_q;

endmodule

[src/dtrd_cordic.sv]
// Two-lane unrolled vectoring CORDIC for azimuth and elevation, halved to Q23.
`timescale 1ns / 1ps
module dtrd_cordic (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  dtrd_pkg::crd_in_t  crd_i,
  output dtrd_pkg::crd_out_t crd_o
);
  import dtrd_pkg::*;

  logic signed [CRD_W-1:0] in_x [2];
  logic signed [CRD_W-1:0] in_y [2];
  logic signed [CRD_W-1:0] pre_x [2];
  logic signed [CRD_W-1:0] pre_y [2];
  logic signed [ANG_W-1:0] pre_a [2];
  logic                    pre_z [2];

  logic                    vld [CORDIC_STEPS+1];
  logic signed [CRD_W-1:0] xs  [CORDIC_STEPS+1][2];
  logic signed [CRD_W-1:0] ys  [CORDIC_STEPS+1][2];
  logic signed [ANG_W-1:0] ang [CORDIC_STEPS+1][2];
  logic                    nz  [CORDIC_STEPS+1][2];

  logic                    out_valid_q;
  logic signed [Q23_W-1:0] half_q [2];

  assign in_x[0] = crd_i.az_x;
  assign in_y[0] = crd_i.az_y;
  assign in_x[1] = crd_i.el_x;
  assign in_y[1] = crd_i.el_y;

  // turn left half-plane vectors by a quarter turn
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      pre_z[l] = (in_x[l] == '0) && (in_y[l] == '0);
      if (in_x[l] < 0) begin
        if (in_y[l] >= 0) begin
          pre_x[l] = in_y[l];
          pre_y[l] = -in_x[l];
          pre_a[l] = HALF_PI_Q30;
        end else begin
          pre_x[l] = -in_y[l];
          pre_y[l] = in_x[l];
          pre_a[l] = -HALF_PI_Q30;
        end
      end else begin
        pre_x[l] = in_x[l];
        pre_y[l] = in_y[l];
        pre_a[l] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld[0] <= 1'b0;
    end else if (en_i) begin
      vld[0] <= crd_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < 2; l++) begin
        xs[0][l]  <= pre_x[l];
        ys[0][l]  <= pre_y[l];
        ang[0][l] <= pre_a[l];
        nz[0][l]  <= pre_z[l];
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[i+1] <= 1'b0;
      end else if (en_i) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int l = 0; l < 2; l++) begin
          if (ys[i][l] > 0) begin
            xs[i+1][l]  <= xs[i][l] + (ys[i][l] >>> i);
            ys[i+1][l]  <= ys[i][l] - (xs[i][l] >>> i);
            ang[i+1][l] <= ang[i][l] + atan_q30(i);
          end else begin
            xs[i+1][l]  <= xs[i][l] - (ys[i][l] >>> i);
            ys[i+1][l]  <= ys[i][l] + (xs[i][l] >>> i);
            ang[i+1][l] <= ang[i][l] - atan_q30(i);
          end
          nz[i+1][l] <= nz[i][l];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      out_valid_q <= vld[CORDIC_STEPS];
    end
  end

  // halve with rounding; a zero vector has angle zero
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < 2; l++) begin
        half_q[l] <= nz[CORDIC_STEPS][l] ? '0
                   : Q23_W'((ang[CORDIC_STEPS][l] + ANG_W'(128)) >>> 8);
      end
    end
  end

  assign crd_o.valid = out_valid_q;
  assign crd_o.az    = half_q[0];
  assign crd_o.el    = half_q[1];

endmodule

[src/dtrd_clamp.sv]
// Disc radius clamp: exact radius test, root, two dividers and Q1.15 rounding.
`timescale 1ns / 1ps
module dtrd_clamp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  dtrd_pkg::crd_out_t                ang_i,
  input  logic [dtrd_pkg::RAD_W-1:0]        clamp_radius_i,
  output dtrd_pkg::res_t                    res_o
);
  import dtrd_pkg::*;

  localparam int OUT_MAX = 32767;
  localparam int OUT_MIN_MAG = 32768;

  function automatic logic signed [OUT_W-1:0] to_q15(input logic signed [Q23_W-1:0] v);
    logic [Q23_W-1:0] mag;
    logic [Q23_W-1:0] rnd;
    logic signed [OUT_W-1:0] r;
    mag = v[Q23_W-1] ? Q23_W'(-v) : Q23_W'(v);
    rnd = (mag + Q23_W'(128)) >> 8;
    if (!v[Q23_W-1]) begin
      r = (rnd > Q23_W'(OUT_MAX)) ? OUT_W'(OUT_MAX) : OUT_W'(rnd);
    end else begin
      r = (rnd > Q23_W'(OUT_MIN_MAG)) ? OUT_W'(OUT_MIN_MAG) : OUT_W'(-rnd);
    end
    return r;
  endfunction

  logic [CR_W-1:0]         cr;
  logic signed [SQ_W-1:0]  axe, aye;
  logic                    v1_q, v2_q;
  logic signed [Q23_W-1:0] ax1_q, ay1_q, ax2_q, ay2_q;
  logic [SQ_W-1:0]         axsq_q, aysq_q, cr2_q, r2;
  logic [SQ_W-1:0]         r2_q;
  logic                    clp2_q;

  logic                    sq_valid;
  logic [ROOT_W-1:0]       sq_root;
  logic [ISQ_PAY_W-1:0]    sq_pay;
  logic signed [Q23_W-1:0] sq_ax, sq_ay;
  logic                    sq_clp;
  logic [Q23_W-1:0]        sq_abx, sq_aby;

  logic                    dv  [QUO_BITS+1];
  logic [DIV_W-1:0]        rem [QUO_BITS+1][2];
  logic [QUO_BITS-1:0]     quo [QUO_BITS+1][2];
  logic [ROOT_W-1:0]       den [QUO_BITS+1];
  logic signed [Q23_W-1:0] av  [QUO_BITS+1][2];
  logic                    clp [QUO_BITS+1];

  logic                    out_valid_q;
  logic signed [OUT_W-1:0] rx_q, ry_q;
  logic                    clamped_q;
  logic signed [Q23_W-1:0] fin [2];

  assign cr  = {clamp_radius_i, 8'd0};
  assign axe = SQ_W'(ang_i.az);
  assign aye = SQ_W'(ang_i.el);
  assign r2  = axsq_q + aysq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= ang_i.valid;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      axsq_q <= SQ_W'(axe * axe);
      aysq_q <= SQ_W'(aye * aye);
      cr2_q  <= SQ_W'(cr) * SQ_W'(cr);
      ax1_q  <= ang_i.az;
      ay1_q  <= ang_i.el;
      r2_q   <= r2;
      clp2_q <= r2 > cr2_q;
      ax2_q  <= ax1_q;
      ay2_q  <= ay1_q;
    end
  end

  dtrd_isqrt u_rsqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en_i),
    .valid_i    (v2_q),
    .radicand_i (ISQ_W'(r2_q)),
    .pay_i      (ISQ_PAY_W'({clp2_q, ax2_q, ay2_q})),
    .valid_o    (sq_valid),
    .root_o     (sq_root),
    .pay_o      (sq_pay)
  );

  assign sq_ay  = sq_pay[Q23_W-1:0];
  assign sq_ax  = sq_pay[2*Q23_W-1:Q23_W];
  assign sq_clp = sq_pay[2*Q23_W];
  assign sq_abx = Q23_W'(sq_ax[Q23_W-1] ? -sq_ax : sq_ax);
  assign sq_aby = Q23_W'(sq_ay[Q23_W-1] ? -sq_ay : sq_ay);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv[0] <= 1'b0;
    end else if (en_i) begin
      dv[0] <= sq_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem[0][0] <= DIV_W'(sq_abx) * DIV_W'(cr);
      rem[0][1] <= DIV_W'(sq_aby) * DIV_W'(cr);
      quo[0][0] <= '0;
      quo[0][1] <= '0;
      den[0]    <= sq_root;
      av[0][0]  <= sq_ax;
      av[0][1]  <= sq_ay;
      clp[0]    <= sq_clp;
    end
  end

  // restoring division, one quotient bit per stage, MSB first
  for (genvar k = 0; k < QUO_BITS; k++) begin : g_div
    localparam int BP = QUO_BITS - 1 - k;
    logic [DIV_W-1:0] dsh;
    assign dsh = DIV_W'(den[k]) << BP;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv[k+1] <= 1'b0;
      end else if (en_i) begin
        dv[k+1] <= dv[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int l = 0; l < 2; l++) begin
          if (rem[k][l] >= dsh) begin
            rem[k+1][l] <= rem[k][l] - dsh;
            quo[k+1][l] <= quo[k][l] | (QUO_BITS'(1) << BP);
          end else begin
            rem[k+1][l] <= rem[k][l];
            quo[k+1][l] <= quo[k][l];
          end
          av[k+1][l] <= av[k][l];
        end
        den[k+1] <= den[k];
        clp[k+1] <= clp[k];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (clp[QUO_BITS]) begin
        fin[l] = av[QUO_BITS][l][Q23_W-1] ? -Q23_W'(quo[QUO_BITS][l])
                                          : Q23_W'(quo[QUO_BITS][l]);
      end else begin
        fin[l] = av[QUO_BITS][l];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      out_valid_q <= dv[QUO_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rx_q      <= to_q15(fin[0]);
      ry_q      <= to_q15(fin[1]);
      clamped_q <= clp[QUO_BITS];
    end
  end

  assign res_o.valid   = out_valid_q;
  assign res_o.radar_x = rx_q;
  assign res_o.radar_y = ry_q;
  assign res_o.clamped = clamped_q;

endmodule

[src/direction_to_radar_disc_core.sv]
// Top level of the radar disc mapper: register port, pipeline and output queue.
// Throughput: one point per cycle while no stall holds the pipeline; it has 115 register
//   stages, and the two-entry output queue keeps taking beats while one result waits.
// A full queue with a result in the last stage freezes every stage at once; nothing is lost.
// Reset is asynchronous and active low: it clears all valid bits and the queue count,
//   zeroes the three matrix columns and sets the clamp radius to 0.45 (14746).
`timescale 1ns / 1ps
`include "assert_macros.svh"
module direction_to_radar_disc_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  dtrd_in_if.sink                       in_i,
  dtrd_out_if.source                    out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dtrd_pkg::PADDR_W-1:0]  paddr,
  input  logic [dtrd_pkg::PDATA_W-1:0]  pwdata,
  output logic [dtrd_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import dtrd_pkg::*;

  // configuration registers, one 64-bit slot each
  logic [PDATA_W-1:0] col_x_q, col_y_q, col_z_q;
  logic [RAD_W-1:0]   clamp_q;
  logic               wr;
  reg_idx_e           idx;

  // pipeline plumbing
  logic               adv;
  xf_t                xf;
  logic               h_valid;
  logic [ROOT_W-1:0]  h_root;
  logic [ISQ_PAY_W-1:0] h_pay;
  logic signed [NORM_W-1:0] hx, hy, hz;
  crd_in_t            crd_in;
  crd_out_t           crd_out;
  res_t               res;

  // output queue: slot 0 drives the port, slot 1 takes the overflow
  res_t               slot0_q, slot1_q;
  logic [1:0]         cnt_q;
  logic [1:0]         left;
  logic               push, pop;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[PADDR_W-1:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_x_q <= '0;
      col_y_q <= '0;
      col_z_q <= '0;
      clamp_q <= CLAMP_RESET;
    end else if (wr) begin
      case (idx)
        REG_COL_X: col_x_q <= pwdata;
        REG_COL_Y: col_y_q <= pwdata;
        REG_COL_Z: col_z_q <= pwdata;
        REG_CLAMP: clamp_q <= pwdata[RAD_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_COL_X: prdata = col_x_q;
      REG_COL_Y: prdata = col_y_q;
      REG_COL_Z: prdata = col_z_q;
      REG_CLAMP: prdata = PDATA_W'(clamp_q);
      default:   prdata = '0;
    endcase
  end

  // Advance the whole pipeline unless a result sits in the last stage and the
  // queue is full. Only registered state decides, so the output ready never
  // reaches the input ready in the same cycle.
  assign adv      = !res.valid || (cnt_q != 2'd2);
  assign in_i.ready = adv;

  // Stage group 1: affine transform, normalization and x*x + z*z.
  dtrd_xform u_xform (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (adv),
    .valid_i   (in_i.valid),
    .world_x_i (in_i.world_x),
    .world_y_i (in_i.world_y),
    .world_z_i (in_i.world_z),
    .col_x_i   (col_x_q),
    .col_y_i   (col_y_q),
    .col_z_i   (col_z_q),
    .xf_o      (xf)
  );

  // Stage group 2: horizontal length, carrying the normalized vector alongside.
  dtrd_isqrt u_hsqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .valid_i    (xf.valid),
    .radicand_i (xf.rad),
    .pay_i      ({xf.x, xf.y, xf.z}),
    .valid_o    (h_valid),
    .root_o     (h_root),
    .pay_o      (h_pay)
  );

  assign hz = h_pay[NORM_W-1:0];
  assign hy = h_pay[2*NORM_W-1:NORM_W];
  assign hx = h_pay[3*NORM_W-1:2*NORM_W];

  // Azimuth is atan2(x, -z); elevation is atan2(y, h).
  assign crd_in.valid = h_valid;
  assign crd_in.az_y  = CRD_W'(hx);
  assign crd_in.az_x  = -CRD_W'(hz);
  assign crd_in.el_y  = CRD_W'(hy);
  assign crd_in.el_x  = CRD_W'({1'b0, h_root});

  // Stage group 3: both angles through one unrolled CORDIC, halved to Q23.
  dtrd_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .crd_i  (crd_in),
    .crd_o  (crd_out)
  );

  // Stage group 4: pull points outside the clamp circle back onto it.
  dtrd_clamp u_clamp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (adv),
    .ang_i          (crd_out),
    .clamp_radius_i (clamp_q),
    .res_o          (res)
  );

  assign push = res.valid && adv;
  assign pop  = (cnt_q != 2'd0) && out_o.ready;
  assign left = cnt_q - {1'b0, pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= left + {1'b0, push};
    end
  end

  // Shift the queue on a pop, then drop a new beat into the first free slot.
  always_ff @(posedge clk_i) begin
    if (pop && (cnt_q == 2'd2)) slot0_q <= slot1_q;
    if (push) begin
      if (left == 2'd0) begin
        slot0_q <= res;
      end else begin
        slot1_q <= res;
      end
    end
  end

  assign out_o.valid   = cnt_q != 2'd0;
  assign out_o.radar_x = slot0_q.radar_x;
  assign out_o.radar_y = slot0_q.radar_y;
  assign out_o.clamped = slot0_q.clamped;

  `DTRD_ASSERT_ALWAYS(a_cnt_range, cnt_q != 2'd3)
  `DTRD_ASSERT_ALWAYS(a_no_overflow, !push || (cnt_q != 2'd2) || pop)
  `DTRD_ASSERT_NEXT(a_stall_holds, res.valid && !adv, res.valid)
  `DTRD_ASSERT_NEXT(a_clamp_write, wr && (idx == REG_CLAMP), clamp_q == $past(pwdata[14:0]))

endmodule
